@@ rtl/filterbank_channel_reverse_unpack_defines.svh @@
// Assertion macros for the checker file of the filterbank unpacker.
// Depends on nothing; included by the checker module.
`ifndef FILTERBANK_CHANNEL_REVERSE_UNPACK_DEFINES_SVH
`define FILTERBANK_CHANNEL_REVERSE_UNPACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBCRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbcru assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBCRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbcru assertion failed");

// Next-cycle implication that is also checked across reset.
`define FBCRU_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fbcru assertion failed");

`endif

@@ rtl/fbcru_pkg.sv @@
// Shared types and constants of the filterbank unpacker.
// Depends on nothing; used by the top level and the sample unpacker.
package fbcru_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CHAN_W   = 13;
    localparam int CFG_W    = 14;
    localparam int OUT_W    = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] REG_PACK_MODE  = 2'd0;
    localparam logic [1:0] REG_CHAN_COUNT = 2'd1;

    localparam logic [1:0] MODE_8BIT = 2'd0;
    localparam logic [1:0] MODE_4BIT = 2'd1;
    localparam logic [1:0] MODE_2BIT = 2'd2;
    localparam logic [1:0] MODE_1BIT = 2'd3;

    localparam logic [CFG_W-1:0] CHAN_COUNT_RESET = 14'd512;

    typedef struct packed {
        logic [SAMPLE_W-1:0] data;
        logic [1:0]          mode;
        logic [CHAN_W-1:0]   ch_base;
        logic                last_pos;
    } t_unpack_req;

    function automatic logic [2:0] last_sample_index(input logic [1:0] mode);
        logic [2:0] r;
        case (mode)
            MODE_8BIT: r = 3'd0;
            MODE_4BIT: r = 3'd1;
            MODE_2BIT: r = 3'd3;
            MODE_1BIT: r = 3'd7;
            default:   r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/fbcru_unpack.sv @@
// Splits one stored byte into its samples, most significant field first,
// and drives the registered output stream. Depends on fbcru_pkg.
module fbcru_unpack (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load_valid,
    input  fbcru_pkg::t_unpack_req  i_load,
    output logic                    o_load_ready,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [fbcru_pkg::OUT_W-1:0] o_m_tdata, // sample, channel, zero fill
    output logic                    o_m_tuser,     // last_of_byte
    output logic                    o_m_tlast      // last_of_spectrum
);
    import fbcru_pkg::*;

    logic                r_busy;
    logic [SAMPLE_W-1:0] r_sh;
    logic [1:0]          r_mode;
    logic [2:0]          r_k;
    logic [CHAN_W-1:0]   r_ch;
    logic                r_last_pos;

    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic [CHAN_W-1:0]   r_o_ch;
    logic                r_o_lb;
    logic                r_o_ls;

    logic                emit;
    logic                k_last;
    logic                load;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] n_sh;

    always_comb begin
        case (r_mode)
            MODE_8BIT: begin
                sample = r_sh;
                n_sh   = '0;
            end
            MODE_4BIT: begin
                sample = {4'b0, r_sh[7:4]};
                n_sh   = {r_sh[3:0], 4'b0};
            end
            MODE_2BIT: begin
                sample = {6'b0, r_sh[7:6]};
                n_sh   = {r_sh[5:0], 2'b0};
            end
            MODE_1BIT: begin
                sample = {7'b0, r_sh[7]};
                n_sh   = {r_sh[6:0], 1'b0};
            end
            default: begin
                sample = r_sh;
                n_sh   = '0;
            end
        endcase
    end

    assign k_last       = (r_k == last_sample_index(r_mode));
    assign emit         = r_busy && (!r_o_valid || i_m_tready);
    assign o_load_ready = !r_busy || (emit && k_last);
    assign load         = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (emit && k_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sh       <= i_load.data;
            r_mode     <= i_load.mode;
            r_k        <= '0;
            r_ch       <= i_load.ch_base;
            r_last_pos <= i_load.last_pos;
        end else if (emit) begin
            r_sh <= n_sh;
            r_k  <= r_k + 3'd1;
            r_ch <= r_ch + CHAN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_sample <= sample;
            r_o_ch     <= r_ch;
            r_o_lb     <= k_last;
            r_o_ls     <= k_last && r_last_pos;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(OUT_W - CHAN_W - SAMPLE_W){1'b0}}, r_o_ch, r_o_sample};
    assign o_m_tuser  = r_o_lb;
    assign o_m_tlast  = r_o_ls;

endmodule

@@ rtl/filterbank_channel_reverse_unpack.sv @@
// Filterbank unpacker top level: ping-pong byte store, reversed read, unpacker.
// An item's byte is registered by the store read stage, then loaded into the unpacker,
// whose output register shows its first sample. The unpacker gives one sample per cycle
// while the output is not stalled; the store takes one write and one read per cycle.
// Reset clears the position, bank and valid flags and the configuration;
// the byte store is not cleared and holds old contents until written.
module filterbank_channel_reverse_unpack #(
    parameter int MAX_CHANNELS = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // packed_byte
    input  logic                          i_s_tuser,  // op
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [fbcru_pkg::OUT_W-1:0]   o_m_tdata,  // sample[7:0], channel[20:8], zeros
    output logic                          o_m_tuser,  // last_of_byte
    output logic                          o_m_tlast,  // last_of_spectrum
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [fbcru_pkg::CFG_W-1:0]   i_cfg_data
);
    import fbcru_pkg::*;

    localparam int PW    = $clog2(MAX_CHANNELS);
    localparam int CW    = PW + 1;
    localparam int EW    = (CW > CFG_W) ? CW : CFG_W;
    localparam int AW    = $clog2(2 * MAX_CHANNELS);
    localparam int DEPTH = 2 * MAX_CHANNELS;
    localparam int SW    = PW + 3;

    function automatic logic [CW-1:0] byte_count(input logic [1:0] mode,
                                                  input logic [CFG_W-1:0] count);
        logic [EW-1:0] c;
        c = EW'({count[CFG_W-1:3], 3'b000});
        if (c == '0) begin
            c = EW'(8);
        end
        if (c > EW'(MAX_CHANNELS)) begin
            c = EW'(MAX_CHANNELS);
        end
        return CW'(c >> mode);
    endfunction

    logic [7:0] mem [DEPTH];

    logic [1:0]       r_mode;
    logic [CFG_W-1:0] r_count;
    logic [CW-1:0]    r_nbytes;
    logic [CW-1:0]    r_last_idx;
    logic [1:0]       n_mode;
    logic [CFG_W-1:0] n_count;
    logic [CW-1:0]    n_nbytes;

    logic [PW-1:0] r_pos;
    logic          r_bank;
    logic          r_prev;
    logic          r_cur;

    logic              r_s1_valid;
    logic              r_s1_emit;
    logic [1:0]        r_s1_mode;
    logic [CHAN_W-1:0] r_s1_ch_base;
    logic              r_s1_last_pos;
    logic [7:0]        r_rd_q;

    logic          cfg_we;
    logic          acc;
    logic          skip;
    logic          wrap;
    logic          n_cur;
    logic [PW-1:0] pos_eff;
    logic [PW-1:0] rd_off;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] ch_wide;
    logic          s1_done;
    logic          load_ready;
    t_unpack_req   load_req;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        if (cfg_we && (i_cfg_index == REG_PACK_MODE)) begin
            n_mode = i_cfg_data[1:0];
        end
        if (cfg_we && (i_cfg_index == REG_CHAN_COUNT)) begin
            n_count = i_cfg_data;
        end
        n_nbytes = byte_count(n_mode, n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_8BIT;
            r_count    <= CHAN_COUNT_RESET;
            r_nbytes   <= byte_count(MODE_8BIT, CHAN_COUNT_RESET);
            r_last_idx <= byte_count(MODE_8BIT, CHAN_COUNT_RESET) - CW'(1);
        end else begin
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_nbytes   <= n_nbytes;
            r_last_idx <= n_nbytes - CW'(1);
        end
    end

    assign pos_eff = (CW'(r_pos) >= r_nbytes) ? '0 : r_pos;
    assign wrap    = (CW'(pos_eff) == r_last_idx);
    assign skip    = (i_s_tuser == OP_DRAIN) && !r_prev && !r_cur;
    assign n_cur   = r_cur || (i_s_tuser == OP_WRITE);
    assign rd_off  = PW'(r_last_idx - CW'(pos_eff));
    assign rd_addr = r_bank ? AW'(rd_off) : AW'(MAX_CHANNELS) + AW'(rd_off);
    assign wr_addr = r_bank ? AW'(MAX_CHANNELS) + AW'(pos_eff) : AW'(pos_eff);
    assign ch_wide = SW'(pos_eff) << r_mode;

    assign s1_done    = r_s1_valid && (!r_s1_emit || load_ready);
    assign o_s_tready = !r_s1_valid || s1_done;
    assign acc        = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (acc && !skip && (i_s_tuser == OP_WRITE)) begin
            mem[wr_addr] <= i_s_tdata;
        end
        if (acc && r_prev) begin
            r_rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_bank <= 1'b0;
            r_prev <= 1'b0;
            r_cur  <= 1'b0;
        end else if (acc) begin
            if (skip) begin
                r_pos <= pos_eff;
            end else if (wrap) begin
                r_pos  <= '0;
                r_bank <= !r_bank;
                r_prev <= n_cur;
                r_cur  <= 1'b0;
            end else begin
                r_pos <= pos_eff + PW'(1);
                r_cur <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_emit     <= r_prev;
            r_s1_mode     <= r_mode;
            r_s1_ch_base  <= CHAN_W'(ch_wide);
            r_s1_last_pos <= wrap;
        end
    end

    always_comb begin
        load_req.data     = r_rd_q;
        load_req.mode     = r_s1_mode;
        load_req.ch_base  = r_s1_ch_base;
        load_req.last_pos = r_s1_last_pos;
    end

    fbcru_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_s1_valid && r_s1_emit),
        .i_load       (load_req),
        .o_load_ready (load_ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

@@ rtl/fbcru_checker.sv @@
// Port-level checks of the filterbank unpacker, bound to the top level.
// Depends on fbcru_pkg and the shared assertion macro header.
`include "filterbank_channel_reverse_unpack_defines.svh"

module fbcru_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [fbcru_pkg::OUT_W-1:0] o_m_tdata,
    input logic                        o_m_tuser,
    input logic                        o_m_tlast
);
    import fbcru_pkg::*;

    // A stalled item keeps its contents.
    `FBCRU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))

    // The end of a spectrum is always the end of a byte.
    `FBCRU_ASSERT_NOW(a_last_in_byte, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser)

    // Zero fill above the channel field stays zero.
    `FBCRU_ASSERT_NOW(a_zero_fill, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[OUT_W-1:SAMPLE_W+CHAN_W] == '0)

    // Reset empties the output register.
    `FBCRU_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind filterbank_channel_reverse_unpack fbcru_checker u_fbcru_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

@@ tb/sv/tb_filterbank_channel_reverse_unpack.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for filterbank_channel_reverse_unpack: directed and random packed
// bytes, with a built-in ping-pong store predictor checking every unpacked sample.
// Depends on fbcru_pkg and the filterbank_channel_reverse_unpack RTL only.
module tb_filterbank_channel_reverse_unpack;
    import fbcru_pkg::*;

    localparam int MAX_CH       = 8192;
    localparam int QUIET_CYCLES = 16;
    localparam int RANDOM_ITEMS = 320;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   channel;
        logic                last_of_byte;
        logic                last_of_spectrum;
    } t_sample;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_op      = OP_WRITE;
    logic [7:0]       s_byte    = 8'h00;
    logic             m_ready   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [1:0]       cfg_index = REG_PACK_MODE;
    logic [CFG_W-1:0] cfg_data  = '0;
    wire              s_ready;
    wire              m_valid;
    wire [OUT_W-1:0]  m_data;
    wire              m_user;
    wire              m_last;
    wire              cfg_ready;

    logic [7:0]       spectrum_mem [0:2*MAX_CH-1];
    bit               ever_written [0:2*MAX_CH-1];
    int unsigned      byte_pos     = 0;
    bit               write_bank   = 1'b0;
    bit               prev_ready   = 1'b0;
    bit               cur_written  = 1'b0;
    bit               hole_seen    = 1'b0;
    logic [1:0]       pack_mode_q  = MODE_8BIT;
    logic [CFG_W-1:0] chan_count_q = CHAN_COUNT_RESET;
    t_sample          expected_samples [$];

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int hold_req  = 0;
    int error_count     = 0;
    int accepted_items  = 0;
    int checked_samples = 0;

    filterbank_channel_reverse_unpack #(
        .MAX_CHANNELS(MAX_CH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_byte),
        .i_s_tuser  (s_op),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    initial begin
        #50ms;
        $display("Timeout: the block stopped making progress.");
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned spectrum_len();
        int unsigned c;
        c = 32'({chan_count_q[CFG_W-1:3], 3'b000});
        if (c == 0) begin
            c = 8;
        end
        if (c > MAX_CH) begin
            c = MAX_CH;
        end
        return c >> pack_mode_q;
    endfunction

    // Returns the operation actually sent. A drain is turned into a write, or a write into
    // a drain, where it would otherwise let a never-written byte be read back later.
    function automatic logic unpack_item(input logic op_req, input logic [7:0] data,
                                         output bit active);
        logic        op;
        int unsigned nb, spb, width, mask, p, wr_idx, k;
        logic [7:0]  stored;
        t_sample     s;
        op    = op_req;
        nb    = spectrum_len();
        spb   = 1 << pack_mode_q;
        width = 8 >> pack_mode_q;
        mask  = (1 << width) - 1;
        if (byte_pos >= nb) begin
            byte_pos = 0;
        end
        p      = byte_pos;
        wr_idx = (write_bank ? MAX_CH : 0) + p;
        active = !(op == OP_DRAIN && !prev_ready && !cur_written);
        if (!active) begin
            return op;
        end
        if (op == OP_DRAIN && cur_written && !ever_written[wr_idx]) begin
            op = OP_WRITE;
        end else if (op == OP_WRITE && !cur_written && hole_seen) begin
            op = OP_DRAIN;
        end
        if (prev_ready) begin
            stored = spectrum_mem[(write_bank ? 0 : MAX_CH) + nb - 1 - p];
            for (k = 0; k < spb; k++) begin
                s.sample           = SAMPLE_W'((int'(stored) >> (8 - width * (k + 1))) & mask);
                s.channel          = CHAN_W'(p * spb + k);
                s.last_of_byte     = (k == spb - 1);
                s.last_of_spectrum = (k == spb - 1) && (p == nb - 1);
                expected_samples.push_back(s);
            end
        end
        if (op == OP_WRITE) begin
            spectrum_mem[wr_idx] = data;
            ever_written[wr_idx] = 1'b1;
            cur_written          = 1'b1;
        end else if (!ever_written[wr_idx]) begin
            hole_seen = 1'b1;
        end
        p++;
        if (p >= nb) begin
            p           = 0;
            write_bank  = !write_bank;
            prev_ready  = cur_written;
            cur_written = 1'b0;
            hole_seen   = 1'b0;
        end
        byte_pos = p;
        return op;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < 100) begin
            $display("ERROR %s: got 0x%0h, expected 0x%0h, at %0t", what, got, want, $time);
        end
        error_count++;
    endtask

    always @(posedge clk) begin : check_samples
        t_sample want;
        if (rst_n && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("sample with none expected", 32'(m_data), 0);
            end else begin
                want = expected_samples.pop_front();
                checked_samples++;
                if (m_data[SAMPLE_W-1:0] !== want.sample) begin
                    report_mismatch("sample", 32'(m_data[SAMPLE_W-1:0]), 32'(want.sample));
                end
                if (m_data[SAMPLE_W+CHAN_W-1:SAMPLE_W] !== want.channel) begin
                    report_mismatch("channel", 32'(m_data[SAMPLE_W+CHAN_W-1:SAMPLE_W]),
                                    32'(want.channel));
                end
                if (m_user !== want.last_of_byte) begin
                    report_mismatch("last_of_byte", 32'(m_user), 32'(want.last_of_byte));
                end
                if (m_last !== want.last_of_spectrum) begin
                    report_mismatch("last_of_spectrum", 32'(m_last),
                                    32'(want.last_of_spectrum));
                end
            end
        end
    end

    always @(posedge clk) begin : drive_ready
        int hold_left;
        int stall_left;
        int r;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!rx_stalls) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                m_ready <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic op_req, input logic [7:0] data);
        logic op;
        bit   active;
        int   r;
        int   gap;
        gap = 0;
        if (tx_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 95) begin
                gap = $urandom_range(8, 30);
            end else if (r >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op = unpack_item(op_req, data, active);
        if (active) begin
            accepted_items++;
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_byte  <= data;
        do @(posedge clk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PACK_MODE:  pack_mode_q = val[1:0];
            REG_CHAN_COUNT: chan_count_q = val;
            default: ;
        endcase
    endtask

    task automatic flush_spectra();
        while (prev_ready || cur_written) begin
            send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic reconfigure(input logic [1:0] mode, input logic [CFG_W-1:0] count);
        flush_spectra();
        write_register(REG_PACK_MODE, CFG_W'(mode));
        write_register(REG_CHAN_COUNT, count);
    endtask

    task automatic test_idle_drain();
        send_item(OP_DRAIN, 8'hFF);
        send_item(OP_DRAIN, 8'h00);
        wait_drained();
    endtask

    task automatic test_one_bit_samples();
        reconfigure(MODE_1BIT, 14'd8);
        send_item(OP_WRITE, 8'hA5);
        send_item(OP_WRITE, 8'hFF);
        send_item(OP_WRITE, 8'h00);
        flush_spectra();
    endtask

    task automatic test_two_bit_samples();
        reconfigure(MODE_2BIT, 14'd15);
        send_item(OP_WRITE, 8'h1B);
        send_item(OP_WRITE, 8'hE4);
        send_item(OP_WRITE, 8'h00);
        send_item(OP_WRITE, 8'hFF);
        flush_spectra();
    endtask

    // A spectrum that is only partly written still reads back the older bytes of its bank.
    task automatic test_partial_spectrum();
        send_item(OP_WRITE, 8'h3C);
        send_item(OP_DRAIN, 8'h00);
        flush_spectra();
    endtask

    task automatic test_four_bit_samples();
        reconfigure(MODE_4BIT, 14'd8);
        send_item(OP_WRITE, 8'h0F);
        send_item(OP_WRITE, 8'hF0);
        send_item(OP_WRITE, 8'h00);
        send_item(OP_WRITE, 8'hFF);
        flush_spectra();
    endtask

    task automatic test_eight_bit_samples();
        reconfigure(MODE_8BIT, 14'd0);
        send_item(OP_WRITE, 8'h00);
        send_item(OP_WRITE, 8'hFF);
        send_item(OP_WRITE, 8'h80);
        send_item(OP_WRITE, 8'h01);
        send_item(OP_WRITE, 8'h55);
        send_item(OP_WRITE, 8'hAA);
        send_item(OP_WRITE, 8'h7F);
        send_item(OP_WRITE, 8'hFE);
        flush_spectra();
    endtask

    // Shrinking the spectrum mid-way puts the write position past its end.
    task automatic test_position_restart();
        reconfigure(MODE_1BIT, 14'd24);
        send_item(OP_WRITE, 8'h5A);
        send_item(OP_WRITE, 8'hC3);
        write_register(REG_CHAN_COUNT, 14'd8);
        send_item(OP_WRITE, 8'h96);
        flush_spectra();
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        reconfigure(MODE_1BIT, 14'd32);
        hold_req = 200;
        repeat (12) send_item(OP_WRITE, 8'($urandom_range(0, 255)));
        wait_drained();
        repeat (8) send_item(OP_WRITE, 8'($urandom_range(0, 255)));
        flush_spectra();
        wait_drained();
        tx_gaps = 1'b1;
    endtask

    // A large channel count must not end the spectrum early; the count is then cut back,
    // so the position restarts and the few bytes written are flushed out.
    task automatic test_largest_spectrum(input logic [CFG_W-1:0] count);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        reconfigure(MODE_1BIT, count);
        repeat (6) send_item(OP_WRITE, 8'($urandom_range(0, 255)));
        write_register(REG_CHAN_COUNT, 14'd8);
        send_item(OP_WRITE, 8'($urandom_range(0, 255)));
        flush_spectra();
        wait_drained();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_random_traffic();
        int               start;
        int               n;
        int               r;
        logic [1:0]       mode;
        logic [CFG_W-1:0] count;
        start = accepted_items;
        while (accepted_items - start < RANDOM_ITEMS) begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            mode      = 2'($urandom_range(0, 3));
            r         = $urandom_range(0, 9);
            if (r < 7) begin
                count = CFG_W'(8 * $urandom_range(1, 8));
            end else if (r == 7) begin
                count = CFG_W'($urandom_range(0, 7));
            end else begin
                count = CFG_W'(8 * $urandom_range(1, 8) + $urandom_range(1, 7));
            end
            reconfigure(mode, count);
            if ($urandom_range(0, 4) == 0) begin
                send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
            end
            n = spectrum_len() * $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 29) == 0) begin
                    wait_drained();
                end
                send_item(($urandom_range(0, 9) == 0) ? OP_DRAIN : OP_WRITE,
                          8'($urandom_range(0, 255)));
            end
        end
        flush_spectra();
        wait_drained();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_drain();
        test_one_bit_samples();
        test_two_bit_samples();
        test_partial_spectrum();
        test_four_bit_samples();
        test_eight_bit_samples();
        test_position_restart();
        test_output_backpressure();
        test_largest_spectrum(14'd8192);
        test_largest_spectrum(14'h3FFF);
        test_random_traffic();
        wait_drained();
        $display("Covered %0d stored or drained items and %0d checked samples,",
                 accepted_items, checked_samples);
        $display("in all pack modes, channel counts from 8 up to the clamped maximum, with stalls.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
